@@ rtl/core/sfha_pkg.sv @@
// Package for the segregated-fit heap allocator.
// Holds the sequencer state type and the command and status codes.
// No dependencies.
`default_nettype none
package sfha_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOFIT   = 2'd1;
  localparam logic [1:0] STAT_BADFREE = 2'd2;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE,
    S_A_BIN, S_A_RD, S_A_CMP, S_A_END, S_A_CUT_CHK, S_A_CUT_RD, S_A_CUT_UP, S_A_CUT_LO,
    S_A_FIN,
    S_F_WALK_RD, S_F_WALK, S_F_CHK, S_F_UP_RD, S_F_UP, S_F_UP_CHK, S_F_LO_RD, S_F_LO,
    S_F_LO_CHK,
    S_J_LO, S_J_UP, S_J_SUM,
    S_CF_RD, S_CF_UP, S_CF_MK_RD, S_CF_MK,
    S_MT_RD, S_MT_UP, S_RM_CHK, S_RM_LNK,
    S_MF_RD, S_MF_UP, S_IN_CHK, S_IN_RD, S_IN_CMP, S_IN_MID, S_IN_FRONT, S_IN_TAIL,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/segregated_fit_heap_allocator.sv @@
// Segregated-fit heap allocator with boundary tags, one sequencer over chunk memories.
// Depends on sfha_pkg.
//
// Channel  Dir  Contents
// s_axis   in   tuser: cmd; tdata: request_bytes, data_offset
// m_axis   out  tdata: status, data_addr
//
// One transaction at a time: allocate reads each chunk examined in the bins it visits,
// plus the list walk of the insert; free reads each chunk on the chain up to the target,
// plus the merges. After reset a clearing pass over all HEAP_BYTES/8 entries runs
// before the first transaction.
// A finished result waits in the output register while the next transaction is taken.
`default_nettype none
module segregated_fit_heap_allocator #(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 24,
  parameter int BIN_COUNT    = 11
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // request_bytes[16:0], data_offset[32:17]
  input  wire logic        s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // status[1:0], data_addr[17:2]
);
  import sfha_pkg::*;

  localparam int GRAN = HEAP_BYTES / 8;
  localparam int GW   = $clog2(GRAN);
  localparam int XW   = GW + 2;
  localparam int SW   = $clog2(HEAP_BYTES + 1);
  localparam int NW   = 19;
  localparam int CW   = (SW > NW) ? SW : NW;
  localparam int FW   = (GW + 1 > 16) ? GW + 1 : 16;
  localparam int BW   = $clog2(BIN_COUNT);
  localparam int BCW  = $clog2(BIN_COUNT + 1);
  localparam int INIT_D   = (HEAP_BYTES - HEADER_BYTES) / 8;
  localparam int INIT_BIN = (INIT_D == 0) ? 0 :
                            ((INIT_D - 1 < BIN_COUNT - 1) ? INIT_D - 1 : BIN_COUNT - 1);

  function automatic logic [GW-1:0] upper_of(input logic [GW-1:0] g, input logic [SW-1:0] s);
    logic [XW-1:0] sum;
    sum = XW'(g) + XW'(s >> 3);
    if (sum >= XW'(GRAN)) sum = sum - XW'(GRAN);
    return sum[GW-1:0];
  endfunction

  function automatic logic [BCW-1:0] bin_of(input logic [CW-1:0] d);
    logic [CW-1:0] b;
    b = d >> 3;
    if (b == '0) return '0;
    if (b - CW'(1) < CW'(BIN_COUNT - 1)) return BCW'(b - CW'(1));
    return BCW'(BIN_COUNT - 1);
  endfunction

  function automatic logic [BCW-1:0] chunk_bin(input logic [SW-1:0] s);
    logic [CW-1:0] d;
    d = (s > SW'(HEADER_BYTES)) ? CW'(s) - CW'(HEADER_BYTES) : '0;
    return bin_of(d);
  endfunction

  logic [SW-1:0] size_mem [GRAN];
  logic [SW-1:0] low_mem  [GRAN];
  logic          mark_mem [GRAN];
  logic [GW-1:0] nxt_mem  [GRAN];
  logic [GW-1:0] prv_mem  [GRAN];

  logic [GW-1:0] ra;
  logic [SW-1:0] rd_s, rd_l;
  logic          rd_m;
  logic [GW-1:0] rd_n, rd_p;

  logic          s_we, l_we, m_we, n_we, p_we;
  logic [GW-1:0] s_wa, l_wa, m_wa, n_wa, p_wa;
  logic [SW-1:0] s_wd, l_wd;
  logic          m_wd;
  logic [GW-1:0] n_wd, p_wd;

  state_t state, state_next, ret, jret;
  logic [GW-1:0] clr, op, it, itp, cg, tmp, aux, best, jlo, jup;
  logic [SW-1:0] sz_op, best_sz, jsz, lower;
  logic          mark, fr, found;
  logic [BCW-1:0] bsel;
  logic [GW-1:0]  bhead [BIN_COUNT];
  logic [GW-1:0]  btail [BIN_COUNT];
  logic [BIN_COUNT-1:0] bused;
  logic [NW-1:0]  need;
  logic [1:0]     status;
  logic [15:0]    addr;
  logic [1:0]     out_status;
  logic [15:0]    out_addr;

  logic [BW-1:0]  bi;
  logic           cur_used;
  logic [GW-1:0]  cur_head, cur_tail;
  logic [16:0]    req;
  logic [15:0]    off, off_adj;
  logic [NW-1:0]  bytes;
  logic           off_bad;
  logic [XW-1:0]  pg, lo_x;
  logic [GW-1:0]  up_rd;
  logic [CW-1:0]  remain;
  logic [GW+3:0]  addr_w;

  assign bi       = bsel[BW-1:0];
  assign cur_used = bused[bi];
  assign cur_head = bhead[bi];
  assign cur_tail = btail[bi];
  assign req      = s_axis_tdata[16:0];
  assign off      = s_axis_tdata[32:17];
  assign off_adj  = off - 16'(HEADER_BYTES);
  assign bytes    = (NW'(req) + NW'(7)) & ~NW'(7);
  assign off_bad  = (17'(off) < 17'(HEADER_BYTES)) || (off_adj[2:0] != 3'd0) ||
                    (FW'(off_adj[15:3]) >= FW'(GRAN));
  assign up_rd    = upper_of(op, rd_s);
  assign remain   = CW'(rd_s) - CW'(need);
  assign addr_w   = {1'b0, best, 3'b000} + (GW+4)'(HEADER_BYTES);

  always_comb begin
    pg = XW'(rd_l >> 3);
    if (pg >= XW'(GRAN)) pg = pg - XW'(GRAN);
    lo_x = (XW'(cg) >= pg) ? XW'(cg) - pg : XW'(cg) + XW'(GRAN) - pg;
  end

  always_ff @(posedge clk) begin
    if (s_we) size_mem[s_wa] <= s_wd;
    if (l_we) low_mem[l_wa] <= l_wd;
    if (m_we) mark_mem[m_wa] <= m_wd;
    if (n_we) nxt_mem[n_wa] <= n_wd;
    if (p_we) prv_mem[p_wa] <= p_wd;
    rd_s <= size_mem[ra];
    rd_l <= low_mem[ra];
    rd_m <= mark_mem[ra];
    rd_n <= nxt_mem[ra];
    rd_p <= prv_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ra = '0;
    s_we = 1'b0; s_wa = '0; s_wd = '0;
    l_we = 1'b0; l_wa = '0; l_wd = '0;
    m_we = 1'b0; m_wa = '0; m_wd = 1'b0;
    n_we = 1'b0; n_wa = '0; n_wd = '0;
    p_we = 1'b0; p_wa = '0; p_wd = '0;
    case (state)
      S_CLEAR: begin
        s_we = 1'b1; l_we = 1'b1; m_we = 1'b1;
        s_wa = clr; l_wa = clr; m_wa = clr;
        s_wd = (clr == '0) ? SW'(HEAP_BYTES) : '0;
        l_wd = s_wd;
        m_wd = (clr == '0);
        if (clr == GW'(GRAN - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == CMD_ALLOC) state_next = (req == '0) ? S_DONE : S_A_BIN;
          else state_next = off_bad ? S_DONE : S_F_WALK_RD;
        end
      end
      S_A_BIN: begin
        if (found || bsel == BCW'(BIN_COUNT)) state_next = S_A_END;
        else if (cur_used) state_next = S_A_RD;
      end
      S_A_RD: begin
        ra = it;
        state_next = S_A_CMP;
      end
      S_A_CMP: state_next = (it == cur_tail) ? S_A_BIN : S_A_RD;
      S_A_END: state_next = found ? S_MT_RD : S_DONE;
      S_A_CUT_CHK: begin
        state_next = (CW'(best_sz) >= CW'(need) + CW'(HEADER_BYTES + 8)) ? S_A_CUT_RD : S_A_FIN;
      end
      S_A_CUT_RD: begin
        ra = best;
        state_next = S_A_CUT_UP;
      end
      S_A_CUT_UP: begin
        s_we = 1'b1; l_we = 1'b1; m_we = 1'b1;
        s_wa = upper_of(best, SW'(need)); l_wa = s_wa; m_wa = s_wa;
        s_wd = SW'(remain);
        l_wd = SW'(need);
        m_wd = 1'b0;
        state_next = S_A_CUT_LO;
      end
      S_A_CUT_LO: begin
        s_we = 1'b1; l_we = 1'b1; m_we = 1'b1;
        s_wa = best; l_wa = best; m_wa = best;
        s_wd = SW'(need);
        l_wd = lower;
        m_wd = mark;
        state_next = S_MF_RD;
      end
      S_A_FIN: state_next = S_DONE;
      S_F_WALK_RD: begin
        ra = it;
        state_next = (it == cg) ? S_CF_RD : S_F_WALK;
      end
      S_F_WALK: state_next = (upper_of(it, rd_s) == '0) ? S_DONE : S_F_WALK_RD;
      S_F_CHK: state_next = fr ? S_DONE : S_MF_RD;
      S_F_UP_RD: begin
        ra = cg;
        state_next = S_F_UP;
      end
      S_F_UP: state_next = S_CF_RD;
      S_F_UP_CHK: state_next = (fr && tmp > cg) ? S_J_LO : S_F_LO_RD;
      S_F_LO_RD: begin
        ra = cg;
        state_next = S_F_LO;
      end
      S_F_LO: state_next = S_CF_RD;
      S_F_LO_CHK: state_next = (fr && tmp < cg) ? S_J_LO : S_DONE;
      S_J_LO: state_next = S_MT_RD;
      S_J_UP: state_next = S_MT_RD;
      S_J_SUM: begin
        s_we = 1'b1;
        s_wa = jlo;
        s_wd = jsz + sz_op;
        state_next = S_MF_RD;
      end
      S_CF_RD: begin
        ra = op;
        state_next = S_CF_UP;
      end
      S_CF_UP: state_next = S_CF_MK_RD;
      S_CF_MK_RD: begin
        ra = aux;
        state_next = S_CF_MK;
      end
      S_CF_MK: state_next = ret;
      S_MT_RD: begin
        ra = op;
        state_next = S_MT_UP;
      end
      S_MT_UP: begin
        m_we = 1'b1;
        m_wa = up_rd;
        m_wd = 1'b0;
        state_next = S_RM_CHK;
      end
      S_RM_CHK: begin
        ra = op;
        state_next = cur_used ? S_RM_LNK : ret;
      end
      S_RM_LNK: begin
        if (cur_head != op && cur_tail != op) begin
          n_we = 1'b1; n_wa = rd_p; n_wd = rd_n;
          p_we = 1'b1; p_wa = rd_n; p_wd = rd_p;
        end
        state_next = ret;
      end
      S_MF_RD: begin
        ra = op;
        state_next = S_MF_UP;
      end
      S_MF_UP: begin
        m_we = 1'b1; m_wa = up_rd; m_wd = 1'b1;
        l_we = 1'b1; l_wa = up_rd; l_wd = rd_s;
        state_next = S_IN_CHK;
      end
      S_IN_CHK: state_next = cur_used ? S_IN_RD : ret;
      S_IN_RD: begin
        ra = it;
        state_next = S_IN_CMP;
      end
      S_IN_CMP: begin
        if (sz_op > rd_s) state_next = S_IN_MID;
        else if (it == cur_tail) state_next = S_IN_TAIL;
        else state_next = S_IN_RD;
      end
      S_IN_MID: begin
        if (it != cur_head) begin
          n_we = 1'b1; n_wa = itp; n_wd = op;
          p_we = 1'b1; p_wa = op; p_wd = itp;
        end
        state_next = S_IN_FRONT;
      end
      S_IN_FRONT: begin
        n_we = 1'b1; n_wa = op; n_wd = it;
        p_we = 1'b1; p_wa = it; p_wd = op;
        state_next = ret;
      end
      S_IN_TAIL: begin
        n_we = 1'b1; n_wa = cur_tail; n_wd = op;
        p_we = 1'b1; p_wa = op; p_wd = cur_tail;
        state_next = ret;
      end
      S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      ret <= S_IDLE;
      jret <= S_IDLE;
      found <= 1'b0;
      bused <= BIN_COUNT'(1) << INIT_BIN;
      for (int i = 0; i < BIN_COUNT; i++) begin
        bhead[i] <= '0;
        btail[i] <= '0;
      end
    end else begin
      case (state)
        S_CLEAR: clr <= clr + GW'(1);
        S_IDLE: begin
          status <= STAT_OK;
          addr <= '0;
          found <= 1'b0;
          bsel <= bin_of(CW'(bytes));
          need <= bytes + NW'(HEADER_BYTES);
          cg <= GW'(off_adj[15:3]);
          it <= '0;
          if (s_axis_tuser == CMD_ALLOC) begin
            if (req == '0) status <= STAT_NOFIT;
          end else if (off_bad) begin
            status <= STAT_BADFREE;
          end
        end
        S_A_BIN: begin
          if (!(found || bsel == BCW'(BIN_COUNT))) begin
            if (cur_used) it <= cur_head;
            else bsel <= bsel + BCW'(1);
          end
        end
        S_A_CMP: begin
          if (CW'(rd_s) >= CW'(need) && (!found || rd_s < best_sz)) begin
            best <= it;
            best_sz <= rd_s;
            found <= 1'b1;
          end
          if (it == cur_tail) bsel <= bsel + BCW'(1);
          else it <= rd_n;
        end
        S_A_END: begin
          if (!found) status <= STAT_NOFIT;
          op <= best;
          ret <= S_A_CUT_CHK;
        end
        S_A_CUT_UP: begin
          tmp <= upper_of(best, SW'(need));
          if (upper_of(best, rd_s) == best) begin
            lower <= SW'(remain);
            mark <= 1'b1;
          end else begin
            lower <= rd_l;
            mark <= rd_m;
          end
        end
        S_A_CUT_LO: begin
          op <= tmp;
          ret <= S_A_FIN;
        end
        S_A_FIN: addr <= 16'(addr_w);
        S_F_WALK_RD: begin
          if (it == cg) begin
            op <= cg;
            ret <= S_F_CHK;
          end
        end
        S_F_WALK: begin
          if (upper_of(it, rd_s) == '0) status <= STAT_BADFREE;
          it <= upper_of(it, rd_s);
        end
        S_F_CHK: begin
          if (fr) status <= STAT_BADFREE;
          op <= cg;
          ret <= S_F_UP_RD;
        end
        S_F_UP: begin
          tmp <= upper_of(cg, rd_s);
          op <= upper_of(cg, rd_s);
          ret <= S_F_UP_CHK;
        end
        S_F_UP_CHK: begin
          jlo <= cg;
          jup <= tmp;
          jret <= S_F_LO_RD;
        end
        S_F_LO: begin
          tmp <= lo_x[GW-1:0];
          op <= lo_x[GW-1:0];
          ret <= S_F_LO_CHK;
        end
        S_F_LO_CHK: begin
          jlo <= tmp;
          jup <= cg;
          jret <= S_DONE;
        end
        S_J_LO: begin
          op <= jlo;
          ret <= S_J_UP;
        end
        S_J_UP: begin
          jsz <= sz_op;
          op <= jup;
          ret <= S_J_SUM;
        end
        S_J_SUM: begin
          op <= jlo;
          ret <= jret;
        end
        S_CF_UP: aux <= up_rd;
        S_CF_MK: fr <= rd_m;
        S_MT_UP, S_MF_UP: begin
          sz_op <= rd_s;
          bsel <= chunk_bin(rd_s);
        end
        S_RM_LNK: begin
          if (cur_head == op && cur_tail == op) bused[bi] <= 1'b0;
          else if (cur_head == op) bhead[bi] <= rd_n;
          else if (cur_tail == op) btail[bi] <= rd_p;
        end
        S_IN_CHK: begin
          if (!cur_used) begin
            bhead[bi] <= op;
            btail[bi] <= op;
            bused[bi] <= 1'b1;
          end else begin
            it <= cur_head;
          end
        end
        S_IN_CMP: begin
          if (sz_op > rd_s) itp <= rd_p;
          else if (it != cur_tail) it <= rd_n;
        end
        S_IN_MID: begin
          if (it == cur_head) bhead[bi] <= op;
        end
        S_IN_TAIL: btail[bi] <= op;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      out_status <= status;
      out_addr <= addr;
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = {6'b000000, out_addr, out_status};

endmodule
`default_nettype wire

@@ tb/sfha_checker.sv @@
`timescale 1ns / 1ps
// Checker for the segregated-fit heap allocator: predicts each result from accepted requests.
// Depends on sfha_pkg; watches the s_axis and m_axis channels of the block.
module sfha_checker #(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 24,
  parameter int BIN_COUNT    = 11
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // request_bytes[16:0], data_offset[32:17]
  input  wire logic        s_axis_tuser,  // cmd
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [23:0] m_axis_tdata,  // status[1:0], data_addr[17:2]
  output int               fail_count,
  output int               pending
);
  import sfha_pkg::*;

  localparam int unsigned GRAN = HEAP_BYTES / 8;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] data_addr;
  } alloc_result_t;

  int unsigned   size_tag[GRAN];
  int unsigned   below_size[GRAN];
  bit            below_free[GRAN];
  int unsigned   link_next[GRAN];
  int unsigned   link_prev[GRAN];
  int unsigned   bin_head[BIN_COUNT];
  int unsigned   bin_tail[BIN_COUNT];
  bit            bin_used[BIN_COUNT];
  alloc_result_t expected_results[$];

  function automatic int unsigned size_bin(int unsigned data_bytes);
    int unsigned b;
    b = data_bytes >> 3;
    if (b == 0) return 0;
    b = b - 1;
    return (b < BIN_COUNT - 1) ? b : BIN_COUNT - 1;
  endfunction

  function automatic int unsigned bin_of_chunk(int unsigned c);
    return size_bin(size_tag[c] > HEADER_BYTES ? size_tag[c] - HEADER_BYTES : 0);
  endfunction

  function automatic int unsigned upper_neighbor(int unsigned c);
    return (c + (size_tag[c] >> 3)) % GRAN;
  endfunction

  function automatic int unsigned lower_neighbor(int unsigned c);
    int unsigned p;
    p = (below_size[c] >> 3) % GRAN;
    return (c >= p) ? c - p : c + GRAN - p;
  endfunction

  function automatic bit is_free(int unsigned c);
    return below_free[upper_neighbor(c)];
  endfunction

  function automatic void bin_insert(int unsigned c);
    int unsigned b, it, p;
    b = bin_of_chunk(c);
    if (!bin_used[b]) begin
      bin_head[b] = c;
      bin_tail[b] = c;
      bin_used[b] = 1;
      return;
    end
    it = bin_head[b];
    for (int n = 0; n < GRAN; n++) begin
      if (size_tag[c] > size_tag[it]) begin
        if (it == bin_head[b]) begin
          bin_head[b] = c;
        end else begin
          p = link_prev[it];
          link_next[p] = c;
          link_prev[c] = p;
        end
        link_next[c] = it;
        link_prev[it] = c;
        return;
      end
      if (it == bin_tail[b]) break;
      it = link_next[it] % GRAN;
    end
    link_next[bin_tail[b]] = c;
    link_prev[c] = bin_tail[b];
    bin_tail[b] = c;
  endfunction

  function automatic void bin_remove(int unsigned c);
    int unsigned b, p, n;
    b = bin_of_chunk(c);
    if (!bin_used[b]) return;
    if (bin_head[b] == c && bin_tail[b] == c) begin
      bin_used[b] = 0;
    end else if (bin_head[b] == c) begin
      bin_head[b] = link_next[c] % GRAN;
    end else if (bin_tail[b] == c) begin
      bin_tail[b] = link_prev[c] % GRAN;
    end else begin
      p = link_prev[c] % GRAN;
      n = link_next[c] % GRAN;
      link_next[p] = n;
      link_prev[n] = p;
    end
  endfunction

  function automatic void take_chunk(int unsigned c);
    below_free[upper_neighbor(c)] = 0;
    bin_remove(c);
  endfunction

  function automatic void release_chunk(int unsigned c);
    int unsigned n;
    n = upper_neighbor(c);
    below_free[n] = 1;
    below_size[n] = size_tag[c];
    bin_insert(c);
  endfunction

  function automatic void write_chunk(int unsigned c, int unsigned sz, int unsigned lo, bit mk);
    size_tag[c] = sz;
    below_size[c] = lo;
    below_free[c] = mk;
  endfunction

  function automatic void merge_chunks(int unsigned lo, int unsigned up);
    take_chunk(lo);
    take_chunk(up);
    write_chunk(lo, size_tag[lo] + size_tag[up], below_size[lo], below_free[lo]);
    release_chunk(lo);
  endfunction

  function automatic void split_chunk(int unsigned c, int unsigned part);
    int unsigned u, whole, lo;
    bit mk;
    u = (c + (part >> 3)) % GRAN;
    whole = size_tag[c];
    lo = below_size[c];
    mk = below_free[c];
    if (upper_neighbor(c) == c) begin
      lo = whole - part;
      mk = 1;
    end
    write_chunk(u, whole - part, part, 0);
    write_chunk(c, part, lo, mk);
    release_chunk(u);
  endfunction

  function automatic bit on_chain(int unsigned target);
    int unsigned c;
    c = 0;
    for (int n = 0; n < GRAN; n++) begin
      if (c == target) return 1;
      c = upper_neighbor(c);
      if (c == 0) break;
    end
    return 0;
  endfunction

  function automatic void heap_reset();
    for (int g = 0; g < GRAN; g++) begin
      size_tag[g] = 0;
      below_size[g] = 0;
      below_free[g] = 0;
      link_next[g] = 0;
      link_prev[g] = 0;
    end
    for (int b = 0; b < BIN_COUNT; b++) begin
      bin_head[b] = 0;
      bin_tail[b] = 0;
      bin_used[b] = 0;
    end
    write_chunk(0, HEAP_BYTES, HEAP_BYTES, 1);
    bin_insert(0);
  endfunction

  function automatic alloc_result_t heap_step(logic cmd, logic [16:0] req, logic [15:0] off);
    alloc_result_t r;
    int unsigned bytes, need, best, it, c, up, lo;
    bit found;
    r.status = STAT_OK;
    r.data_addr = '0;
    if (cmd == CMD_ALLOC) begin
      bytes = (int'(req) + 7) & ~32'd7;
      if (bytes == 0) begin
        r.status = STAT_NOFIT;
      end else begin
        need = bytes + HEADER_BYTES;
        found = 0;
        best = 0;
        for (int unsigned b = size_bin(bytes); b < BIN_COUNT && !found; b++) begin
          if (!bin_used[b]) continue;
          it = bin_head[b];
          for (int n = 0; n < GRAN; n++) begin
            if (size_tag[it] >= need && (!found || size_tag[it] < size_tag[best])) begin
              best = it;
              found = 1;
            end
            if (it == bin_tail[b]) break;
            it = link_next[it] % GRAN;
          end
        end
        if (!found) begin
          r.status = STAT_NOFIT;
        end else begin
          take_chunk(best);
          if (size_tag[best] >= need + HEADER_BYTES + 8) split_chunk(best, need);
          r.data_addr = 16'(best * 8 + HEADER_BYTES);
        end
      end
    end else begin
      if (off < HEADER_BYTES || ((off - HEADER_BYTES) & 7) != 0) begin
        r.status = STAT_BADFREE;
      end else begin
        c = (off - HEADER_BYTES) >> 3;
        if (c >= GRAN || !on_chain(c) || is_free(c)) begin
          r.status = STAT_BADFREE;
        end else begin
          release_chunk(c);
          up = upper_neighbor(c);
          if (is_free(up) && up > c) merge_chunks(c, up);
          lo = lower_neighbor(c);
          if (is_free(lo) && lo < c) merge_chunks(lo, c);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t got, want;
    int errs;
    if (rst) begin
      heap_reset();
      expected_results.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      errs = 0;
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(heap_step(s_axis_tuser, s_axis_tdata[16:0],
                                             s_axis_tdata[32:17]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[1:0], m_axis_tdata[17:2]};
        if (expected_results.size() == 0) begin
          $error("unexpected result status=%0d data_addr=%0d", got.status, got.data_addr);
          errs = errs + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errs = errs + 1;
          end
          if (got.data_addr !== want.data_addr) begin
            $error("data_addr expected %0d actual %0d", want.data_addr, got.data_addr);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= expected_results.size();
    end
  end
endmodule

@@ tb/tb_segregated_fit_heap_allocator.sv @@
`timescale 1ns / 1ps
// Top of the heap allocator testbench: clock, reset, request stimulus and the verdict.
// Depends on sfha_pkg, sfha_checker and segregated_fit_heap_allocator.
module tb_segregated_fit_heap_allocator;
  import sfha_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // request_bytes[16:0], data_offset[32:17]
  logic        s_axis_tuser = 0;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;       // status[1:0], data_addr[17:2]
  int          fail_count;
  int          pending;
  bit          quiet = 0;
  logic [15:0] live_blocks[$];
  logic [15:0] freed_blocks[$];

  always #2 clk = ~clk;

  segregated_fit_heap_allocator u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  sfha_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(0, 99) >= 10);
    if (!rst && m_axis_tvalid && m_axis_tready && m_axis_tdata[1:0] == STAT_OK &&
        m_axis_tdata[17:2] != 0)
      live_blocks.push_back(m_axis_tdata[17:2]);
  end

  task automatic send_request(logic cmd, logic [16:0] req, logic [15:0] off);
    s_axis_tvalid <= 1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {7'd0, off, req};
    forever begin
      @(negedge clk);
      if (s_axis_tready) begin
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
    if (!quiet && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic free_live();
    int k;
    logic [15:0] a;
    if (live_blocks.size() == 0) begin
      send_request(CMD_FREE, '0, 16'($urandom_range(0, 65535)));
    end else begin
      k = $urandom_range(0, live_blocks.size() - 1);
      a = live_blocks[k];
      live_blocks.delete(k);
      freed_blocks.push_back(a);
      if (freed_blocks.size() > 20) void'(freed_blocks.pop_front());
      send_request(CMD_FREE, '0, a);
    end
  endtask

  initial begin
    int r;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_request(CMD_ALLOC, 17'd0, 16'd0);
    send_request(CMD_ALLOC, 17'd65536, 16'd0);
    send_request(CMD_ALLOC, 17'd65512, 16'd0);
    send_request(CMD_FREE, '0, 16'd24);
    send_request(CMD_FREE, '0, 16'd24);
    send_request(CMD_ALLOC, 17'd1, 16'd0);
    send_request(CMD_ALLOC, 17'd8, 16'd0);
    send_request(CMD_ALLOC, 17'd100, 16'd0);
    send_request(CMD_ALLOC, 17'd65536, 16'd0);
    send_request(CMD_FREE, '0, 16'd0);
    send_request(CMD_FREE, '0, 16'd25);
    send_request(CMD_FREE, '0, 16'd65535);
    send_request(CMD_FREE, '0, 16'd32);
    send_request(CMD_FREE, '0, 16'd56);
    send_request(CMD_FREE, '0, 16'd56);
    send_request(CMD_FREE, '0, 16'd24);
    send_request(CMD_ALLOC, 17'd4000, 16'd0);
    send_request(CMD_ALLOC, 17'd70000 & 17'h1FFFF, 16'hFFFF);

    for (int i = 0; i < 1500; i++) begin
      quiet = (i >= 600 && i < 900);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_request(1'($urandom), 17'($urandom), 16'($urandom));
      end else if (r < 14 && freed_blocks.size() > 0) begin
        send_request(CMD_FREE, '0, freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
      end else if (r < 50 || (live_blocks.size() > 40 && r < 80)) begin
        free_live();
      end else if (r < 95) begin
        send_request(CMD_ALLOC, 17'($urandom_range(1, 200)), 16'($urandom));
      end else begin
        send_request(CMD_ALLOC, 17'($urandom_range(201, 65536)), 16'($urandom));
      end
    end
    s_axis_tvalid <= 0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS segregated_fit_heap_allocator");
    end else begin
      $display("FAIL segregated_fit_heap_allocator");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("FAIL segregated_fit_heap_allocator");
    $finish;
  end
endmodule
